// ===== sv/hsv2rgb_pkg.sv =====
// shared constants, channel record type and helper functions for the hsv to rgb converter
// no dependencies; imported by hsv2rgb_datapath, hsv_to_rgb_converter and the testbench
`default_nettype none

package hsv2rgb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int IN_W      = FRAC_BITS + 1;
	// hue * 6 stays below 12 * 2^FRAC_BITS
	localparam int H6_W      = FRAC_BITS + 4;
	localparam int SEC_W     = H6_W - FRAC_BITS;
	localparam int PROD_W    = 2 * IN_W;
	localparam int BYTE_W    = 8;

	localparam logic [IN_W-1:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

	// sector numbers of the colour wheel
	localparam logic [SEC_W-1:0] SEC_RED     = SEC_W'(0);
	localparam logic [SEC_W-1:0] SEC_YELLOW  = SEC_W'(1);
	localparam logic [SEC_W-1:0] SEC_GREEN   = SEC_W'(2);
	localparam logic [SEC_W-1:0] SEC_CYAN    = SEC_W'(3);
	localparam logic [SEC_W-1:0] SEC_BLUE    = SEC_W'(4);
	localparam logic [SEC_W-1:0] SEC_MAGENTA = SEC_W'(5);

	typedef struct packed {
		logic [SEC_W-1:0] sector;
		logic [IN_W-1:0]  v;
		logic [IN_W-1:0]  p;
		logic [IN_W-1:0]  q;
		logic [IN_W-1:0]  t;
	} hsv2rgb_chan_t;

	function automatic logic [IN_W-1:0] sat_one(input logic [IN_W-1:0] x);
		return (x > ONE_FX) ? ONE_FX : x;
	endfunction

	// floor(255 * x) for x in 0 .. 1.0
	function automatic logic [BYTE_W-1:0] to_byte(input logic [IN_W-1:0] x);
		logic [IN_W+BYTE_W-1:0] prod;
		prod = {x, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, x};
		return prod[FRAC_BITS+BYTE_W-1:FRAC_BITS];
	endfunction

endpackage

`default_nettype wire

// ===== sv/hsv2rgb_datapath.sv =====
// first three pipeline stages: sector split, the s products, then q and t
// depends on hsv2rgb_pkg
`default_nettype none

module hsv2rgb_datapath
	import hsv2rgb_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_vld,
	input  wire logic [IN_W-1:0]     hue,
	input  wire logic [IN_W-1:0]     saturation,
	input  wire logic [IN_W-1:0]     brightness,
	output logic                     vld_s3,
	output hsv2rgb_chan_t            chan_s3
);

	logic                 vld_s1, vld_s2;
	logic [SEC_W-1:0]     sector_s1, sector_s2;
	logic [FRAC_BITS-1:0] f_s1;
	logic [IN_W-1:0]      s_s1, v_s1, v_s2;
	logic [FRAC_BITS-1:0] fs_s2;
	logic [IN_W-1:0]      gs_s2, p_s2;

	logic [H6_W-1:0]   h6;
	logic [PROD_W-1:0] fs_prod, gs_prod, p_prod, q_prod, t_prod;

	// hue * 6 as two shifted adds
	assign h6 = (H6_W'(hue) << 2) + (H6_W'(hue) << 1);

	assign fs_prod = {1'b0, f_s1} * s_s1;
	assign gs_prod = (ONE_FX - {1'b0, f_s1}) * s_s1;
	assign p_prod  = v_s1 * (ONE_FX - s_s1);

	assign q_prod = v_s2 * (ONE_FX - {1'b0, fs_s2});
	assign t_prod = v_s2 * (ONE_FX - gs_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		sector_s1 <= h6[H6_W-1:FRAC_BITS];
		f_s1      <= h6[FRAC_BITS-1:0];
		s_s1      <= sat_one(saturation);
		v_s1      <= sat_one(brightness);

		sector_s2 <= sector_s1;
		v_s2      <= v_s1;
		fs_s2     <= fs_prod[2*FRAC_BITS-1:FRAC_BITS];
		gs_s2     <= gs_prod[2*FRAC_BITS:FRAC_BITS];
		p_s2      <= p_prod[2*FRAC_BITS:FRAC_BITS];

		chan_s3.sector <= sector_s2;
		chan_s3.v      <= v_s2;
		chan_s3.p      <= p_s2;
		chan_s3.q      <= q_prod[2*FRAC_BITS:FRAC_BITS];
		chan_s3.t      <= t_prod[2*FRAC_BITS:FRAC_BITS];
	end

endmodule

`default_nettype wire

// ===== sv/hsv_to_rgb_converter.sv =====
// hsv to rgb converter top level: datapath instance, sector routing and output stage
// depends on hsv2rgb_pkg and hsv2rgb_datapath
//
// usage:
// - an input transfer happens at a rising edge with start high and busy low;
//   busy is held low, so a pixel can be presented on every cycle
// - hue, saturation and brightness are unsigned with FRAC_BITS fraction bits;
//   saturation and brightness above 1.0 are clipped, a hue of 1.0 or more gives white
// - each result appears on red, green and blue for one cycle with done high;
//   done follows the start edge through vld_s1, vld_s2, vld_s3 and done_s4;
//   one pixel per clock sustained
// - the four stages are: sector split, the three s products, q and t,
//   then routing and scaling by 255 into the output registers
// - the receiver cannot hold results off, so nothing ever backs up
// - reset clears all valid bits; no pixel in flight survives it
`default_nettype none

module hsv_to_rgb_converter
	import hsv2rgb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [IN_W-1:0]   hue,
	input  wire logic [IN_W-1:0]   saturation,
	input  wire logic [IN_W-1:0]   brightness,
	output logic                   done,
	output logic [BYTE_W-1:0]      red,
	output logic [BYTE_W-1:0]      green,
	output logic [BYTE_W-1:0]      blue
);

	logic             vld_s3;
	hsv2rgb_chan_t    chan_s3;
	logic             done_s4;
	logic [BYTE_W-1:0] red_s4, green_s4, blue_s4;
	logic [IN_W-1:0]  r_sel, g_sel, b_sel;

	assign busy = 1'b0;

	hsv2rgb_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (start),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.vld_s3     (vld_s3),
		.chan_s3    (chan_s3)
	);

	always_comb begin
		case (chan_s3.sector)
			SEC_RED: begin
				r_sel = chan_s3.v; g_sel = chan_s3.t; b_sel = chan_s3.p;
			end
			SEC_YELLOW: begin
				r_sel = chan_s3.q; g_sel = chan_s3.v; b_sel = chan_s3.p;
			end
			SEC_GREEN: begin
				r_sel = chan_s3.p; g_sel = chan_s3.v; b_sel = chan_s3.t;
			end
			SEC_CYAN: begin
				r_sel = chan_s3.p; g_sel = chan_s3.q; b_sel = chan_s3.v;
			end
			SEC_BLUE: begin
				r_sel = chan_s3.t; g_sel = chan_s3.p; b_sel = chan_s3.v;
			end
			SEC_MAGENTA: begin
				r_sel = chan_s3.v; g_sel = chan_s3.p; b_sel = chan_s3.q;
			end
			// hue at or past a full turn
			default: begin
				r_sel = ONE_FX; g_sel = ONE_FX; b_sel = ONE_FX;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		red_s4   <= to_byte(r_sel);
		green_s4 <= to_byte(g_sel);
		blue_s4  <= to_byte(b_sel);
	end

	assign done  = done_s4;
	assign red   = red_s4;
	assign green = green_s4;
	assign blue  = blue_s4;

	// every transfer comes out with done high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##4 done)
		else $error("result missing four cycles after start");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s3))
		else $error("result strobe without an item in the last stage");

	// zero saturation inside the wheel gives grey
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start, 4) && ($past(saturation, 4) == '0)
			&& ($past(hue, 4) < ONE_FX))
		|-> (red == green) && (green == blue))
		else $error("zero saturation did not give grey");

endmodule

`default_nettype wire

// ===== tb/hsv_to_rgb_converter_test.sv =====
// self-checking testbench for hsv_to_rgb_converter: directed sector and clipping pixels, then
// random pixel streams under varying sender gaps, each result checked against an in-bench model
// depends on hsv2rgb_pkg and hsv_to_rgb_converter
`timescale 1ns / 1ps

module hsv_to_rgb_converter_test;
	import hsv2rgb_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int TAIL_CYCLES  = 8;
	localparam int STREAM_ITEMS = 350;

	typedef struct packed {
		logic [BYTE_W-1:0] red;
		logic [BYTE_W-1:0] green;
		logic [BYTE_W-1:0] blue;
	} rgb_pixel_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [IN_W-1:0]   hue = '0;
	logic [IN_W-1:0]   saturation = '0;
	logic [IN_W-1:0]   brightness = '0;
	logic              busy;
	logic              done;
	logic [BYTE_W-1:0] red;
	logic [BYTE_W-1:0] green;
	logic [BYTE_W-1:0] blue;

	rgb_pixel_t pending_pixels[$];
	int         mismatch_count = 0;
	int         cycle_count = 0;
	int         idle_pct = 0;

	hsv_to_rgb_converter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.done       (done),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	always #10 clk = ~clk;

	// floor(255 * x), x at most 1.0
	function automatic logic [BYTE_W-1:0] channel_byte(input logic [IN_W-1:0] x);
		logic [IN_W+BYTE_W-1:0] scaled;
		scaled = (IN_W+BYTE_W)'(x) * (IN_W+BYTE_W)'(255);
		return scaled[FRAC_BITS +: BYTE_W];
	endfunction

	function automatic rgb_pixel_t hsv_pixel_rgb(input logic [IN_W-1:0] h, s_in, v_in);
		logic [IN_W-1:0]      s, v, fs, gs, p, q, t, r, g, b;
		logic [H6_W-1:0]      h6;
		logic [SEC_W-1:0]     sector;
		logic [FRAC_BITS-1:0] f;
		logic [PROD_W-1:0]    prod_fs, prod_gs, prod_p, prod_q, prod_t;
		rgb_pixel_t           px;
		s = (s_in > ONE_FX) ? ONE_FX : s_in;
		v = (v_in > ONE_FX) ? ONE_FX : v_in;
		h6 = H6_W'(h) * H6_W'(6);
		sector = h6[H6_W-1:FRAC_BITS];
		f = h6[FRAC_BITS-1:0];
		prod_fs = f * s;
		prod_gs = (ONE_FX - f) * s;
		fs = prod_fs[FRAC_BITS +: IN_W];
		gs = prod_gs[FRAC_BITS +: IN_W];
		prod_p = v * (ONE_FX - s);
		prod_q = v * (ONE_FX - fs);
		prod_t = v * (ONE_FX - gs);
		p = prod_p[FRAC_BITS +: IN_W];
		q = prod_q[FRAC_BITS +: IN_W];
		t = prod_t[FRAC_BITS +: IN_W];
		case (sector)
			SEC_RED: begin
				r = v; g = t; b = p;
			end
			SEC_YELLOW: begin
				r = q; g = v; b = p;
			end
			SEC_GREEN: begin
				r = p; g = v; b = t;
			end
			SEC_CYAN: begin
				r = p; g = q; b = v;
			end
			SEC_BLUE: begin
				r = t; g = p; b = v;
			end
			SEC_MAGENTA: begin
				r = v; g = p; b = q;
			end
			default: begin
				// hue of one or more
				r = ONE_FX; g = ONE_FX; b = ONE_FX;
			end
		endcase
		px.red = channel_byte(r);
		px.green = channel_byte(g);
		px.blue = channel_byte(b);
		return px;
	endfunction

	task automatic check_channel(input string name, input logic [BYTE_W-1:0] want, got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// results are checked before the transfer on the same edge is predicted
	always @(posedge clk) begin
		rgb_pixel_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_pixels.size() == 0) begin
					$display("%0t: result with none expected, expected nothing actual %0d %0d %0d",
						$time, red, green, blue);
					mismatch_count++;
				end else begin
					want = pending_pixels.pop_front();
					check_channel("red", want.red, red);
					check_channel("green", want.green, green);
					check_channel("blue", want.blue, blue);
				end
			end
			if (start && !busy)
				pending_pixels.push_back(hsv_pixel_rgb(hue, saturation, brightness));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("hsv_to_rgb_converter regression: fail");
			$finish;
		end
	end

	task automatic send_pixel(input logic [IN_W-1:0] h, s, v);
		// each idle cycle is drawn on its own, so idle_pct is the share of idle cycles
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		hue <= h;
		saturation <= s;
		brightness <= v;
		do @(posedge clk); while (busy);
	endtask

	// sender holds off until every pending result has come back
	task automatic wait_results_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic test_sector_boundaries();
		// first hue of each sector, the top of the first and the last one, and white hues
		send_pixel(0, ONE_FX, ONE_FX);
		send_pixel(10923, ONE_FX, ONE_FX);
		send_pixel(21846, ONE_FX, ONE_FX);
		send_pixel(32768, ONE_FX, ONE_FX);
		send_pixel(43691, ONE_FX, ONE_FX);
		send_pixel(54614, ONE_FX, ONE_FX);
		send_pixel(10922, ONE_FX, 40000);
		send_pixel(65535, ONE_FX, ONE_FX);
		send_pixel(ONE_FX, ONE_FX, ONE_FX);
		send_pixel('1, 0, 0);
		send_pixel(ONE_FX + 1, 12345, 54321);
		wait_results_drained();
	endtask

	task automatic test_clipping_extremes();
		send_pixel(5000, 0, ONE_FX);
		send_pixel(30000, ONE_FX, 0);
		send_pixel(50000, 0, 0);
		send_pixel(20000, '1, '1);
		send_pixel(40000, ONE_FX + 1, ONE_FX + 1);
		send_pixel(60000, ONE_FX, '1);
		send_pixel(15000, '1, 32768);
		send_pixel(27307, 32768, ONE_FX);
		send_pixel(65535, ONE_FX - 1, ONE_FX - 1);
		wait_results_drained();
	endtask

	task automatic test_random_stream(input int pct);
		logic [IN_W-1:0] h, s, v;
		int              k;
		idle_pct = pct;
		repeat (STREAM_ITEMS) begin
			case ($urandom_range(9))
				0: h = IN_W'($urandom_range(2**IN_W - 1));
				1: begin
					// just around a sector change
					k = $urandom_range(6, 1);
					h = IN_W'((k * 65536 + 5) / 6 + int'($urandom_range(2)) - 1);
				end
				default: h = IN_W'($urandom_range(ONE_FX - 1));
			endcase
			case ($urandom_range(9))
				0: s = 0;
				1: s = ONE_FX;
				2: s = IN_W'($urandom_range(2**IN_W - 1));
				default: s = IN_W'($urandom_range(ONE_FX));
			endcase
			case ($urandom_range(9))
				0: v = 0;
				1: v = ONE_FX;
				2: v = IN_W'($urandom_range(2**IN_W - 1));
				default: v = IN_W'($urandom_range(ONE_FX));
			endcase
			send_pixel(h, s, v);
		end
		wait_results_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_sector_boundaries();
		test_clipping_extremes();
		test_random_stream(26);
		test_random_stream(48);
		test_random_stream(0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_pixels.size() == 0)
			$display("hsv_to_rgb_converter regression: pass");
		else
			$display("hsv_to_rgb_converter regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/hsv2rgb_pkg.sv
sv/hsv2rgb_datapath.sv
sv/hsv_to_rgb_converter.sv
tb/hsv_to_rgb_converter_test.sv
